>>> rtl/core/pwlci_pkg.sv
// Shared types and constants for the piecewise linear curve interpolator.
package pwlci_pkg;

  // Value format: signed 48-bit fixed point
  localparam int VW = 48;
  // Quotient width: anything at or above 2^49 saturates
  localparam int QW = VW + 1;
  // Product width of two 48-bit magnitudes
  localparam int PW = 2 * VW;
  // Multiplier digit width and digit count (3 x 17 covers 48 bits)
  localparam int DW = 17;
  localparam int ND = 3;

  typedef logic signed [VW-1:0] val_t;
  typedef logic [VW-1:0]        mag_t;
  typedef logic [QW-1:0]        quo_t;

  // Request types
  localparam logic [1:0] REQ_WRITE    = 2'd0;
  localparam logic [1:0] REQ_AREA_VOL = 2'd1;
  localparam logic [1:0] REQ_DEP_VOL  = 2'd2;
  localparam logic [1:0] REQ_VOL_DEP  = 2'd3;

  // Result status codes
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_ZDIFF = 2'd1;
  localparam logic [1:0] STS_SAT   = 2'd2;

  localparam val_t VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VW-1){1'b0}}};

  // Status from the multiply/divide unit
  typedef struct packed {
    logic done;
    logic ovf;
  } arith_sts_t;

endpackage

>>> rtl/core/pwlci_muldiv.sv
// Sequential: |a|*|b| in 17-bit digits; restoring divide by |d| unless ovf.
module pwlci_muldiv (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  pwlci_pkg::mag_t     a_mag,
  input  pwlci_pkg::mag_t     b_mag,
  input  pwlci_pkg::mag_t     d_mag,
  output pwlci_pkg::arith_sts_t sts,
  output pwlci_pkg::quo_t     quo
);
  import pwlci_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_CHK  = 2'd2;
  localparam logic [1:0] PH_DIV  = 2'd3;

  logic [1:0]          phase_r;
  logic [5:0]          cnt_r;
  logic                done_r;
  logic                ovf_r;
  mag_t                a_r;
  mag_t                d_r;
  logic [DW*ND-1:0]    b_r;
  logic [PW-1:0]       acc_r;
  mag_t                rem_r;
  quo_t                q_r;

  logic [DW-1:0]       dig;
  logic [VW+DW-1:0]    part;
  logic [VW:0]         trial;
  logic                fits;

  // One digit product per cycle, MSB digit first
  assign dig  = b_r[DW*ND-1 -: DW];
  assign part = a_r * dig;
  // Restoring step: shift in the next dividend bit, try subtract
  assign trial = {rem_r, q_r[QW-1]};
  assign fits  = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (phase_r)
        PH_IDLE: begin
          if (start) begin
            phase_r <= PH_MUL;
          end
        end
        PH_MUL: begin
          if (cnt_r == 6'(ND - 1)) begin
            phase_r <= PH_CHK;
          end
        end
        PH_CHK: begin
          // quotient of 2^49 or more: saturate without dividing
          if (acc_r[PW-1:QW] >= d_r[VW-2:0] && d_r[VW-1] == 1'b0) begin
            phase_r <= PH_IDLE;
            done_r  <= 1'b1;
          end else begin
            phase_r <= PH_DIV;
          end
        end
        PH_DIV: begin
          if (cnt_r == 6'(QW - 1)) begin
            phase_r <= PH_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: phase_r <= PH_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (phase_r)
      PH_IDLE: begin
        a_r   <= a_mag;
        d_r   <= d_mag;
        b_r   <= {{(DW*ND-VW){1'b0}}, b_mag};
        acc_r <= '0;
        cnt_r <= '0;
      end
      PH_MUL: begin
        acc_r <= {acc_r[PW-DW-1:0], {DW{1'b0}}} + PW'(part);
        b_r   <= {b_r[DW*(ND-1)-1:0], {DW{1'b0}}};
        cnt_r <= cnt_r + 6'd1;
      end
      PH_CHK: begin
        ovf_r <= (acc_r[PW-1:QW] >= d_r[VW-2:0]) && (d_r[VW-1] == 1'b0);
        rem_r <= {1'b0, acc_r[PW-1:QW]};
        q_r   <= acc_r[QW-1:0];
        cnt_r <= '0;
      end
      PH_DIV: begin
        rem_r <= fits ? VW'(trial - {1'b0, d_r}) : trial[VW-1:0];
        q_r   <= {q_r[QW-2:0], fits};
        cnt_r <= cnt_r + 6'd1;
      end
      default: cnt_r <= '0;
    endcase
  end

  assign sts.done = done_r;
  assign sts.ovf  = ovf_r;
  assign quo      = q_r;

  // A saturating result is never reported after a full divide pass
  a_quick_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DIV) |=> !ovf_r) else $error("ovf set during divide");
  // Done pulses for one cycle only
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done held");
  // Done only rises once the unit is back in idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> phase_r == PH_IDLE) else $error("done while busy");

endmodule

>>> rtl/core/piecewise_linear_curve_interpolator_core.sv
// Top level of the piecewise linear curve interpolator: table store, scan and control.
//
// Use: one request channel (in_*) and one result channel (out_*), both valid/stall.
// A request with in_req_type write stores one table row (depth, volume, area) at
// in_row_index and answers result 0, status ok. The other types look up in_query_key
// in the volume or depth column and interpolate along the chosen segment.
// Every request gives exactly one result, in order.
// A write goes through the done state to the result register. A query scans one row
// per cycle from the single read port of the row memory, up to the first row after
// row 0 at or below the key, else the last row searched; then prepare, digit multiply,
// check, restoring divide, hand-back, final add and the move to the result register.
// A zero key difference skips the arithmetic; a quotient found too large at the check
// skips the divide. One request is worked on at a time; the next can be taken in the
// cycle after this one has been handed to the result register.
// Reset clears control and sets rows_in_use to 2; table rows are undefined until
// written. in_stall is high from acceptance until the result moves to the result
// register; while out_stall holds a result there, the next one waits and in_stall
// stays high. cfg_wr_en writes rows_in_use; write it only when idle.
module piecewise_linear_curve_interpolator_core #(
  parameter int MAX_ROWS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [6:0]        cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_req_type,
  input  logic [5:0]        in_row_index,
  input  pwlci_pkg::val_t   in_row_depth,
  input  pwlci_pkg::val_t   in_row_volume,
  input  pwlci_pkg::val_t   in_row_area,
  input  pwlci_pkg::val_t   in_query_key,
  output logic              out_valid,
  input  logic              out_stall,
  output pwlci_pkg::val_t   out_result_value,
  output logic [1:0]        out_status
);
  import pwlci_pkg::*;

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (AW + 1 > 7) ? AW + 1 : 7;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_PREP  = 3'd2;
  localparam logic [2:0] ST_ARITH = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]       state_r;
  logic [6:0]       rows_r;
  logic [1:0]       req_r;
  val_t             key_r;
  logic [AW-1:0]    idx_r;
  val_t             prev_k_r, prev_v_r;
  val_t             x0_r, x1_r, y0_r, y1_r;
  logic             neg_r;
  val_t             res_r;
  logic [1:0]       sts_r;
  logic             out_valid_r;
  val_t             out_val_r;
  logic [1:0]       out_sts_r;

  // Row memory: {depth, volume, area}
  logic [3*VW-1:0]  mem [MAX_ROWS];
  logic [3*VW-1:0]  rd_data_r;
  logic [AW-1:0]    rd_addr;

  logic             accept;
  logic             wr_ok;
  logic [CW-1:0]    rows_clamp;
  logic [AW-1:0]    last_idx;
  val_t             cur_d, cur_vo, cur_a, cur_k, cur_v;
  logic             hit;
  logic signed [VW:0] dx, da, db;
  mag_t             dx_mag, da_mag, db_mag;
  arith_sts_t       ar_sts;
  quo_t             ar_quo;
  logic signed [VW+2:0] sum;
  logic             out_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign wr_ok    = CW'(in_row_index) < CW'(MAX_ROWS);

  // Rows searched, clamped to [2, MAX_ROWS]
  always_comb begin
    if (rows_r < 7'd2) begin
      rows_clamp = CW'(2);
    end else if (CW'(rows_r) > CW'(MAX_ROWS)) begin
      rows_clamp = CW'(MAX_ROWS);
    end else begin
      rows_clamp = CW'(rows_r);
    end
  end
  assign last_idx = AW'(rows_clamp - CW'(1));

  // Memory port: write on accepted write request, read every cycle
  assign rd_addr = (state_r == ST_SCAN) ? idx_r + AW'(1) : '0;
  always_ff @(posedge clk) begin
    if (accept && in_req_type == REQ_WRITE && wr_ok) begin
      mem[AW'(in_row_index)] <= {in_row_depth, in_row_volume, in_row_area};
    end
    rd_data_r <= mem[rd_addr];
  end

  // Column select for the request type
  assign cur_d  = rd_data_r[3*VW-1:2*VW];
  assign cur_vo = rd_data_r[2*VW-1:VW];
  assign cur_a  = rd_data_r[VW-1:0];
  always_comb begin
    case (req_r)
      REQ_VOL_DEP: begin
        cur_k = cur_d;
        cur_v = cur_vo;
      end
      REQ_AREA_VOL: begin
        cur_k = cur_vo;
        cur_v = cur_a;
      end
      default: begin
        cur_k = cur_vo;
        cur_v = cur_d;
      end
    endcase
  end
  assign hit = key_r >= cur_k;

  // Segment differences and magnitudes
  assign dx = {key_r[VW-1], key_r} - {x0_r[VW-1], x0_r};
  assign db = {y0_r[VW-1], y0_r} - {y1_r[VW-1], y1_r};
  assign da = {x0_r[VW-1], x0_r} - {x1_r[VW-1], x1_r};
  assign dx_mag = dx[VW] ? VW'(-dx) : dx[VW-1:0];
  assign db_mag = db[VW] ? VW'(-db) : db[VW-1:0];
  assign da_mag = da[VW] ? VW'(-da) : da[VW-1:0];

  pwlci_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_PREP && x0_r != x1_r),
    .a_mag (dx_mag),
    .b_mag (db_mag),
    .d_mag (da_mag),
    .sts   (ar_sts),
    .quo   (ar_quo)
  );

  // Final add with range check
  assign sum = neg_r ? ({{3{y0_r[VW-1]}}, y0_r} - {2'b00, ar_quo})
                     : ({{3{y0_r[VW-1]}}, y0_r} + {2'b00, ar_quo});

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rows_r      <= 7'd2;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        rows_r <= cfg_wr_data;
      end
      // Result register: filled from DONE, emptied when taken
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= (in_req_type == REQ_WRITE) ? ST_DONE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (idx_r != '0 && (hit || idx_r == last_idx)) begin
            state_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          state_r <= (x0_r == x1_r) ? ST_DONE : ST_ARITH;
        end
        ST_ARITH: begin
          if (ar_sts.done) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        req_r <= in_req_type;
        key_r <= in_query_key;
        idx_r <= '0;
        res_r <= '0;
        sts_r <= STS_OK;
      end
      ST_SCAN: begin
        // top segment is the default; a later hit replaces it
        if (idx_r != '0 && (idx_r == AW'(1) || hit)) begin
          x0_r <= prev_k_r;
          y0_r <= prev_v_r;
          x1_r <= cur_k;
          y1_r <= cur_v;
        end
        prev_k_r <= cur_k;
        prev_v_r <= cur_v;
        idx_r    <= idx_r + AW'(1);
      end
      ST_PREP: begin
        neg_r <= dx[VW] ^ db[VW] ^ da[VW];
        if (x0_r == x1_r) begin
          res_r <= '0;
          sts_r <= STS_ZDIFF;
        end
      end
      ST_FIN: begin
        if (ar_sts.ovf) begin
          res_r <= neg_r ? VAL_MIN : VAL_MAX;
          sts_r <= STS_SAT;
        end else if (sum > $signed({{3{1'b0}}, VAL_MAX})) begin
          res_r <= VAL_MAX;
          sts_r <= STS_SAT;
        end else if (sum < $signed({{3{1'b1}}, VAL_MIN})) begin
          res_r <= VAL_MIN;
          sts_r <= STS_SAT;
        end else begin
          res_r <= sum[VW-1:0];
          sts_r <= STS_OK;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_val_r <= res_r;
          out_sts_r <= sts_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_val_r;
  assign out_status       = out_sts_r;

  // Only defined status codes leave the block
  a_sts_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STS_OK || out_status == STS_ZDIFF ||
                   out_status == STS_SAT)) else $error("bad status code");
  // Zero key difference always answers zero
  a_zdiff_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STS_ZDIFF) |-> out_result_value == '0)
    else $error("nonzero result on zero difference");
  // Saturation lands on a bound
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STS_SAT) |->
      (out_result_value == VAL_MAX || out_result_value == VAL_MIN))
    else $error("saturated result off bound");
  // Arithmetic unit only finishes while the core waits for it
  a_arith_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ar_sts.done |-> state_r == ST_ARITH) else $error("stray arith done");

endmodule
